@@ rtl/core/gfed_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gfed_pkg
// Shared types and constants for the GPI frame event decoder.
// -----------------------------------------------------------------------------
package gfed_pkg;

	localparam int MAX_PORTS = 16;
	localparam int NUM_PORTS_DEF = 16;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_IN   = 8'h69;
	localparam logic [7:0] CH_OUT  = 8'h6F;

	localparam logic [CFG_IDX_W-1:0] REG_SUBSCRIBED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TALLY      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLARITY   = 2'd2;

	typedef enum logic [2:0] {
		KIND_IN_COUNT  = 3'd0,
		KIND_OUT_COUNT = 3'd1,
		KIND_TRIGGER   = 3'd2,
		KIND_LEVEL     = 3'd3,
		KIND_UNSUB     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
	} frame_t;

	typedef struct packed {
		logic        switch_level;
		logic [8:0]  port_count;
		logic [8:0]  port_number;
		kind_t       event_kind;
	} result_t;

	localparam int RES_W = $bits(result_t);
	localparam int TDATA_OUT_W = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

@@ rtl/core/gfed_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gfed_frame
// Byte position counter and frame capture; holds a complete frame in the
// input stage until the decoder takes it.
// -----------------------------------------------------------------------------
module gfed_frame import gfed_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   byte_valid,
	output logic        byte_ready,
	input  wire logic [7:0] byte_data,
	input  wire logic   take,
	output logic        frame_valid,
	output frame_t      frame
);

	logic [1:0] pos_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       v_s1;
	frame_t     frame_s1;
	logic       acc;

	assign byte_ready  = !v_s1 || take;
	assign acc         = byte_valid && byte_ready;
	assign frame_valid = v_s1;
	assign frame       = frame_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			v_s1  <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= pos_q + 2'd1;
			end
			if (acc && pos_q == 2'd3) begin
				v_s1 <= 1'b1;
			end else if (take) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && pos_q == 2'd0) begin
			first_q <= byte_data;
		end
		if (acc && pos_q == 2'd1) begin
			second_q <= byte_data;
		end
		if (acc && pos_q == 2'd3) begin
			frame_s1.first_byte  <= first_q;
			frame_s1.second_byte <= second_q;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/gfed_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gfed_decode
// Configuration registers, per-port level tracking and frame decode.
// -----------------------------------------------------------------------------
module gfed_decode import gfed_pkg::*; #(
	parameter int NUM_PORTS = NUM_PORTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 take,
	input  wire frame_t               frame,
	output logic                      emit,
	output result_t                   res
);

	localparam int PIDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	logic [CFG_W-1:0]     sub_q;
	logic [CFG_W-1:0]     tally_q;
	logic [CFG_W-1:0]     pol_q;
	logic [NUM_PORTS-1:0] last_level_q;
	logic                 in_known_q;
	logic                 out_known_q;

	logic [7:0]        fb;
	logic [7:0]        sb;
	logic [7:0]        diff;
	logic [PIDX_W-1:0] pidx;
	logic              is_in;
	logic              is_out;
	logic              in_range;
	logic              sub_bit;
	logic              tally_bit;
	logic              pol_bit;
	logic              lvl;
	logic              prev;
	logic              fire;
	logic              pulse_upd;

	assign fb       = frame.first_byte;
	assign sb       = frame.second_byte;
	assign diff     = fb - CH_ZERO;
	assign pidx     = diff[PIDX_W-1:0];
	assign is_in    = (fb == CH_IN);
	assign is_out   = (fb == CH_OUT);
	assign in_range = (fb >= CH_ZERO) && (diff < 8'(NUM_PORTS));
	assign sub_bit  = sub_q[diff[3:0]];
	assign tally_bit = tally_q[diff[3:0]];
	assign pol_bit  = pol_q[diff[3:0]];
	assign lvl      = (sb == CH_ONE);
	assign prev     = last_level_q[pidx];
	assign fire     = pol_bit ? (prev && !lvl) : (!prev && lvl);
	assign pulse_upd = !is_in && !is_out && in_range && sub_bit && !tally_bit;

	always_comb begin
		res.event_kind   = KIND_UNSUB;
		res.port_number  = {1'b0, fb} - 9'd48;
		res.port_count   = 9'd0;
		res.switch_level = 1'b0;
		emit             = 1'b1;
		if (is_in || is_out) begin
			res.event_kind  = is_in ? KIND_IN_COUNT : KIND_OUT_COUNT;
			res.port_number = 9'd0;
			res.port_count  = {1'b0, sb} - 9'd48;
			emit            = is_in ? !in_known_q : !out_known_q;
		end else if (in_range && sub_bit) begin
			if (tally_bit) begin
				res.event_kind   = KIND_LEVEL;
				res.switch_level = lvl ^ pol_bit;
			end else begin
				res.event_kind = KIND_TRIGGER;
				emit           = fire;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q        <= '0;
			tally_q      <= '0;
			pol_q        <= '0;
			last_level_q <= '0;
			in_known_q   <= 1'b0;
			out_known_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SUBSCRIBED: begin
						for (int p = 0; p < NUM_PORTS; p++) begin
							if (cfg_data[p] && !sub_q[p]) begin
								last_level_q[p] <= 1'b0;
							end
						end
						sub_q <= cfg_data;
					end
					REG_TALLY:    tally_q <= cfg_data;
					REG_POLARITY: pol_q   <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				if (is_in) begin
					in_known_q <= 1'b1;
				end
				if (is_out) begin
					out_known_q <= 1'b1;
				end
				if (pulse_upd) begin
					last_level_q[pidx] <= lvl;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/gfed_outreg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gfed_outreg
// Result register on the master side.
// -----------------------------------------------------------------------------
module gfed_outreg import gfed_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic emit,
	input  wire result_t res,
	output logic      space,
	output logic      out_valid,
	input  wire logic out_ready,
	output result_t   out_res
);

	logic    v_q;
	result_t res_q;

	assign space     = !v_q || out_ready;
	assign out_valid = v_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (load) begin
			v_q <= emit;
		end else if (out_ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/gpi_frame_event_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gpi_frame_event_decoder
// Decodes 4-byte GPI frames into count, trigger, level and notice events.
//
//   channel   dir   handshake              payload
//   s_*       in    s_tvalid / s_tready    s_tdata: rx_byte
//   m_*       out   m_tvalid / m_tready    m_tdata: event result
//   cfg_*     in    cfg_we                 cfg_index, cfg_data
//
// One byte per cycle sustained while m_tready does not stall the result. The fourth
// byte of a frame is registered in the frame stage, then in the result register.
// Reset clears byte position, counts-known flags, levels and registers.
// A stalled result holds; one more frame can wait in the frame stage.
// -----------------------------------------------------------------------------
module gpi_frame_event_decoder import gfed_pkg::*; #(
	parameter int NUM_PORTS = NUM_PORTS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,   // [7:0] rx_byte
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [TDATA_OUT_W-1:0]      m_tdata,   // [2:0] event_kind, [11:3] port_number,
	                                               // [20:12] port_count, [21] switch_level
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	logic    frame_valid;
	frame_t  frame;
	logic    space;
	logic    take;
	logic    emit;
	result_t res;
	result_t out_res;

	assign take = frame_valid && space;

	gfed_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (s_tvalid),
		.byte_ready  (s_tready),
		.byte_data   (s_tdata),
		.take        (take),
		.frame_valid (frame_valid),
		.frame       (frame)
	);

	gfed_decode #(
		.NUM_PORTS (NUM_PORTS)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.frame     (frame),
		.emit      (emit),
		.res       (res)
	);

	gfed_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.emit      (emit),
		.res       (res),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {{(TDATA_OUT_W - RES_W){1'b0}}, out_res};

endmodule
`default_nettype wire

@@ rtl/core/gfed_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// gfed_checker
// Port-level checks for the GPI frame event decoder.
// -----------------------------------------------------------------------------
module gfed_checker import gfed_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [TDATA_OUT_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= KIND_UNSUB)
		else $error("bad event kind");

	a_count_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == KIND_IN_COUNT || m_tdata[2:0] == KIND_OUT_COUNT)
		|-> m_tdata[11:3] == 9'd0 && m_tdata[21] == 1'b0)
		else $error("count event carries port fields");

	a_port_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] != KIND_LEVEL |-> m_tdata[21] == 1'b0)
		else $error("level set on non-level event");

	a_ready_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> s_tready && !m_tvalid)
		else $error("not ready after reset");

endmodule

bind gpi_frame_event_decoder gfed_checker u_gfed_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
